[rtl/nmds_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nmds_pkg
// Shared widths, constants and types of the normal map diffuse shader.
// ----------------------------------------------------------------------------
package nmds_pkg;

	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 1;
	localparam int PIX_W     = 24;
	localparam int SHADE_W   = 8;
	localparam int Q_BITS    = 15;
	localparam int LQ_W      = Q_BITS + 1;
	localparam int DOT_FRAC  = 23;
	localparam int Z_MAG     = 100;

	localparam logic [CFG_IDX_W-1:0] REG_LIGHT_X = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Y = 1'b1;

	typedef struct packed {
		logic signed [LQ_W-1:0] lx;
		logic signed [LQ_W-1:0] ly;
		logic signed [LQ_W-1:0] lz;
	} light_vec_t;

endpackage
`default_nettype wire

[rtl/nmds_light.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nmds_light
// Light registers and the sequencer that normalizes the light vector to
// Q1.15 by a bisection on each component, one compare per ST_SQ/ST_MUL step.
// ----------------------------------------------------------------------------
module nmds_light #(
	parameter int LIGHT_CENTER = 256
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [nmds_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [nmds_pkg::CFG_W-1:0]     cfg_data,
	output      logic                           busy,
	output      nmds_pkg::light_vec_t           light
);
	import nmds_pkg::*;

	localparam int CW   = $clog2(LIGHT_CENTER + 1);
	localparam int MAGW = (CW > CFG_W) ? CW : CFG_W;
	localparam int DXW  = MAGW + 1;
	localparam int SW   = 2 * MAGW + 2;
	localparam int SHW  = 2 * Q_BITS + 2;
	localparam int TW   = 2 * MAGW + SHW;
	localparam int SQW  = 2 * LQ_W;
	localparam int PW   = SQW + SW;
	localparam logic signed [DXW-1:0] CENTER = DXW'(LIGHT_CENTER);
	localparam logic [LQ_W-1:0] HI_INIT = LQ_W'(1) << Q_BITS;
	localparam logic [LQ_W-1:0] R_MAX   = (LQ_W'(1) << Q_BITS) - LQ_W'(1);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SUM  = 5'b00010,
		ST_INIT = 5'b00100,
		ST_SQ   = 5'b01000,
		ST_MUL  = 5'b10000
	} lstate_t;

	lstate_t           state_q;
	logic              pend_q;
	logic [CFG_W-1:0]  light_x_q, light_y_q;
	logic [1:0]        comp_q;
	logic [SW-1:0]     s_q;
	logic [TW-1:0]     target_q;
	logic              neg_q;
	logic [LQ_W-1:0]   lo_q, hi_q, mid_q;
	logic [SQW-1:0]    tsq_q;
	logic signed [LQ_W-1:0] lx_q, ly_q, lz_q;

	logic signed [DXW-1:0]   dx, dy, dsel;
	logic signed [2*DXW-1:0] dx2, dy2;
	logic [DXW-1:0]          dabs;
	logic [MAGW-1:0]         mag;
	logic [2*MAGW-1:0]       mag_sq;
	logic [LQ_W:0]           mid_sum;
	logic [LQ_W-1:0]         mid, t, r;
	logic [PW-1:0]           prod;
	logic signed [LQ_W-1:0]  rval;

	always_comb begin
		dx   = $signed({{(DXW-CFG_W){1'b0}}, light_x_q}) - CENTER;
		dy   = $signed({{(DXW-CFG_W){1'b0}}, light_y_q}) - CENTER;
		dx2  = dx * dx;
		dy2  = dy * dy;
		unique case (comp_q)
			2'd0:    dsel = dx;
			2'd1:    dsel = dy;
			default: dsel = -DXW'(Z_MAG);
		endcase
		dabs    = dsel[DXW-1] ? DXW'(-dsel) : DXW'(dsel);
		mag     = dabs[MAGW-1:0];
		mag_sq  = mag * mag;
		mid_sum = {1'b0, lo_q} + {1'b0, hi_q} + (LQ_W+1)'(1);
		mid     = mid_sum[LQ_W:1];
		t       = (mid << 1) - LQ_W'(1);
		prod    = PW'(tsq_q) * PW'(s_q);
		r       = lo_q[Q_BITS] ? R_MAX : lo_q;
		rval    = neg_q ? -$signed(r) : $signed(r);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_x_q <= CFG_W'(256);
			light_y_q <= CFG_W'(256);
			state_q   <= ST_SUM;
			pend_q    <= 1'b0;
			comp_q    <= 2'd0;
		end else begin
			if (cfg_we) begin
				pend_q <= 1'b1;
				unique case (cfg_index)
					REG_LIGHT_X: light_x_q <= cfg_data;
					REG_LIGHT_Y: light_y_q <= cfg_data;
					default:     ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pend_q && !cfg_we) begin
						pend_q  <= 1'b0;
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					comp_q  <= 2'd0;
					state_q <= ST_INIT;
				end
				ST_INIT: state_q <= ST_SQ;
				ST_SQ: begin
					if (lo_q == hi_q) begin
						if (comp_q == 2'd2) begin
							state_q <= ST_IDLE;
						end else begin
							comp_q  <= comp_q + 2'd1;
							state_q <= ST_INIT;
						end
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL:  state_q <= ST_SQ;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_SUM: s_q <= SW'(dx2) + SW'(dy2) + SW'(Z_MAG * Z_MAG);
			ST_INIT: begin
				target_q <= {mag_sq, {SHW{1'b0}}};
				neg_q    <= dsel[DXW-1];
				lo_q     <= '0;
				hi_q     <= HI_INIT;
			end
			ST_SQ: begin
				mid_q <= mid;
				tsq_q <= t * t;
				if (lo_q == hi_q) begin
					unique case (comp_q)
						2'd0:    lx_q <= rval;
						2'd1:    ly_q <= rval;
						default: lz_q <= rval;
					endcase
				end
			end
			ST_MUL: begin
				if (prod <= PW'(target_q))
					lo_q <= mid_q;
				else
					hi_q <= mid_q - LQ_W'(1);
			end
			default: ;
		endcase
	end

	assign busy     = (state_q != ST_IDLE) || pend_q;
	assign light.lx = lx_q;
	assign light.ly = ly_q;
	assign light.lz = lz_q;

endmodule
`default_nettype wire

[rtl/nmds_pipe.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nmds_pipe
// Four-stage shading pipeline: decode, products, sum and clamp, round.
// ----------------------------------------------------------------------------
module nmds_pipe (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire nmds_pkg::light_vec_t         light,
	input  wire logic                         in_valid,
	output      logic                         in_ready,
	input  wire logic [nmds_pkg::PIX_W-1:0]   normal_pixel,
	output      logic                         out_valid,
	input  wire logic                         out_stall,
	output      logic [nmds_pkg::SHADE_W-1:0] shade,
	output      logic [nmds_pkg::PIX_W-1:0]   gray_pixel
);
	import nmds_pkg::*;

	localparam int PRW = LQ_W + 8;
	localparam int PZW = LQ_W + 10;
	localparam int SUMW = PZW + 2;
	localparam int DW  = DOT_FRAC + 1;
	localparam int PPW = DW + 8;
	localparam logic [DOT_FRAC-1:0] HALF = DOT_FRAC'(1) << (DOT_FRAC - 1);

	logic v1, v2, v3, v4;
	logic rdy1, rdy2, rdy3, rdy4;

	logic signed [7:0]       nr_s1, ng_s1;
	logic [7:0]              b_s1;
	logic signed [PRW-1:0]   px_s2, py_s2;
	logic signed [PZW-1:0]   pz_s2;
	logic [DW-1:0]           dot_s3;
	logic [SHADE_W-1:0]      shade_s4;

	logic signed [SUMW-1:0]  sum;
	logic [PPW-1:0]          p;
	logic [SHADE_W-1:0]      q;
	logic [DOT_FRAC-1:0]     rem;
	logic [SHADE_W:0]        qr;

	assign rdy4     = !v4 || !out_stall;
	assign rdy3     = !v3 || rdy4;
	assign rdy2     = !v2 || rdy3;
	assign rdy1     = !v1 || rdy2;
	assign in_ready = rdy1;

	always_comb begin
		sum = SUMW'(px_s2) + SUMW'(py_s2) + SUMW'(pz_s2);
		p   = (PPW'(dot_s3) << 8) - PPW'(dot_s3);
		q   = p[DOT_FRAC +: SHADE_W];
		rem = p[DOT_FRAC-1:0];
		qr  = {1'b0, q} + (SHADE_W+1)'((rem > HALF) || ((rem == HALF) && q[0]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1 <= 1'b0;
			v2 <= 1'b0;
			v3 <= 1'b0;
			v4 <= 1'b0;
		end else begin
			if (rdy1) v1 <= in_valid;
			if (rdy2) v2 <= v1;
			if (rdy3) v3 <= v2;
			if (rdy4) v4 <= v3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			nr_s1 <= $signed({~normal_pixel[23], normal_pixel[22:16]});
			ng_s1 <= $signed({~normal_pixel[15], normal_pixel[14:8]});
			b_s1  <= normal_pixel[7:0];
		end
		if (rdy2 && v1) begin
			px_s2 <= light.lx * nr_s1;
			py_s2 <= light.ly * ng_s1;
			pz_s2 <= -(PZW'(light.lz) * $signed({2'b00, b_s1}));
		end
		if (rdy3 && v2) begin
			if (sum < 0)
				dot_s3 <= '0;
			else if (sum > SUMW'(1) <<< DOT_FRAC)
				dot_s3 <= DW'(1) << DOT_FRAC;
			else
				dot_s3 <= sum[DW-1:0];
		end
		if (rdy4 && v3)
			shade_s4 <= qr[SHADE_W] ? {SHADE_W{1'b1}} : qr[SHADE_W-1:0];
	end

	assign out_valid  = v4;
	assign shade      = shade_s4;
	assign gray_pixel = {shade_s4, shade_s4, shade_s4};

endmodule
`default_nettype wire

[rtl/normal_map_diffuse_shader.sv]
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one pixel per cycle through the four-stage shading pipeline
// while neither the light normalizer, a register write nor out_stall holds it.
// After reset and after each register write the light normalizer runs three
// bisections, one per component, in ST_SQ/ST_MUL step pairs; input is
// stalled meanwhile. Reset is asynchronous, active low; lights default to 256.
// ----------------------------------------------------------------------------
// normal_map_diffuse_shader
// Per-pixel diffuse shading of a normal map against a configurable light.
// ----------------------------------------------------------------------------
module normal_map_diffuse_shader #(
	parameter int LIGHT_CENTER = 256
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [nmds_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [nmds_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                           in_valid,
	output      logic                           in_stall,
	input  wire logic [nmds_pkg::PIX_W-1:0]     normal_pixel,
	output      logic                           out_valid,
	input  wire logic                           out_stall,
	output      logic [nmds_pkg::SHADE_W-1:0]   shade,
	output      logic [nmds_pkg::PIX_W-1:0]     gray_pixel
);
	import nmds_pkg::*;

	light_vec_t light;
	logic       busy;
	logic       pipe_ready;

	nmds_light #(.LIGHT_CENTER(LIGHT_CENTER)) u_light (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.busy      (busy),
		.light     (light)
	);

	nmds_pipe u_pipe (
		.clk          (clk),
		.arst_n       (arst_n),
		.light        (light),
		.in_valid     (in_valid && !busy && !cfg_we),
		.in_ready     (pipe_ready),
		.normal_pixel (normal_pixel),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.shade        (shade),
		.gray_pixel   (gray_pixel)
	);

	assign in_stall = busy || cfg_we || !pipe_ready;

endmodule
`default_nettype wire

[rtl/nmds_check.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nmds_check
// Port-level checks of the shader, bound to the top level.
// ----------------------------------------------------------------------------
module nmds_check (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           cfg_we,
	input wire logic                           in_valid,
	input wire logic                           in_stall,
	input wire logic [nmds_pkg::PIX_W-1:0]     normal_pixel,
	input wire logic                           out_valid,
	input wire logic                           out_stall,
	input wire logic [nmds_pkg::SHADE_W-1:0]   shade,
	input wire logic [nmds_pkg::PIX_W-1:0]     gray_pixel
);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(normal_pixel))
		else $error("input changed while stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(shade))
		else $error("result changed while stalled");

	a_gray: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> gray_pixel[23:16] == shade && gray_pixel[15:8] == shade
			&& gray_pixel[7:0] == shade)
		else $error("gray pixel bytes differ from shade");

	a_cfg_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> in_stall ##1 in_stall)
		else $error("input taken during light update");

endmodule

bind normal_map_diffuse_shader nmds_check u_nmds_check (.*);
`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the normal map diffuse shader: computes the light
// unit vector and the expected shade per pixel transfer, compares every
// result transfer field by field, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
	import nmds_pkg::*;

	typedef struct packed {
		logic [SHADE_W-1:0] shade;
		logic [PIX_W-1:0]   gray;
	} shade_res_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_LIGHT_X;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [PIX_W-1:0]     normal_pixel = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [SHADE_W-1:0]   shade;
	logic [PIX_W-1:0]     gray_pixel;

	normal_map_diffuse_shader u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
		.normal_pixel(normal_pixel), .out_valid(out_valid), .out_stall(out_stall),
		.shade(shade), .gray_pixel(gray_pixel)
	);

	always #5 clk = ~clk;

	localparam int CENTER    = 256;
	localparam int IDLE_LIMIT = 20000;

	shade_res_t  expected_shades[$];
	int          errors = 0;
	int          pixels_sent = 0;
	int          shades_seen = 0;
	int          idle_cycles = 0;
	bit          quiet = 0;
	bit          hold_off = 0;
	logic [CFG_W-1:0] cur_lx = CFG_W'(CENTER), cur_ly = CFG_W'(CENTER);
	longint      lvx, lvy, lvz;

	function automatic longint unit_q15(longint d, longint s);
		longint m, lo, hi, mid, t;
		m = d < 0 ? -d : d;
		lo = 0;
		hi = 1 << Q_BITS;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			t = 2 * mid - 1;
			if (t * t * s <= m * m * (64'd1 << (2 * Q_BITS + 2)))
				lo = mid;
			else
				hi = mid - 1;
		end
		if (lo > 32767)
			lo = 32767;
		return d < 0 ? -lo : lo;
	endfunction

	function automatic void update_light();
		longint dx, dy, s;
		dx = longint'(cur_lx) - CENTER;
		dy = longint'(cur_ly) - CENTER;
		s = dx * dx + dy * dy + Z_MAG * Z_MAG;
		lvx = unit_q15(dx, s);
		lvy = unit_q15(dy, s);
		lvz = unit_q15(-Z_MAG, s);
	endfunction

	function automatic shade_res_t diffuse_shade(logic [PIX_W-1:0] px);
		longint dot, p, q, rem;
		shade_res_t r;
		dot = lvx * (longint'(px[23:16]) - 128) + lvy * (longint'(px[15:8]) - 128)
			- lvz * longint'(px[7:0]);
		if (dot < 0)
			dot = 0;
		if (dot > (64'd1 << DOT_FRAC))
			dot = 64'd1 << DOT_FRAC;
		p = dot * 255;
		q = p >> DOT_FRAC;
		rem = p & ((64'd1 << DOT_FRAC) - 1);
		if (rem > (64'd1 << (DOT_FRAC - 1)) || (rem == (64'd1 << (DOT_FRAC - 1)) && q[0]))
			q++;
		if (q > 255)
			q = 255;
		r.shade = q[7:0];
		r.gray = {q[7:0], q[7:0], q[7:0]};
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		shade_res_t e;
		if (arst_n && out_valid && !out_stall) begin
			shades_seen++;
			if (expected_shades.size() == 0) begin
				errors++;
				$display("%0t: unexpected result shade=%0d", $time, shade);
			end else begin
				e = expected_shades.pop_front();
				if (shade !== e.shade) begin
					errors++;
					$display("%0t: shade expected %0d actual %0d", $time, e.shade, shade);
				end
				if (gray_pixel !== e.gray) begin
					errors++;
					$display("%0t: gray_pixel expected %h actual %h", $time, e.gray,
						gray_pixel);
				end
			end
		end
	end

	// receiver stall: random bursts, or a long hold-off
	always @(posedge clk) begin
		int n;
		if (hold_off) begin
			out_stall <= 1'b1;
			repeat (300) @(posedge clk);
			hold_off = 0;
			out_stall <= 1'b0;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			n = $urandom_range(1, 11);
			out_stall <= 1'b1;
			repeat (n) @(posedge clk);
			out_stall <= 1'b0;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_off)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("** normal_map_diffuse_shader: FAILED **");
			$finish;
		end
	end

	task automatic send_pixel(logic [PIX_W-1:0] px);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		normal_pixel <= px;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_shades.push_back(diffuse_shade(px));
		pixels_sent++;
	endtask

	task automatic end_burst();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (expected_shades.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_LIGHT_X)
			cur_lx = val;
		else
			cur_ly = val;
		update_light();
	endtask

	task automatic set_light(logic [CFG_W-1:0] x, logic [CFG_W-1:0] y);
		drain();
		write_reg(REG_LIGHT_X, x);
		write_reg(REG_LIGHT_Y, y);
	endtask

	task automatic random_pixels(int n);
		repeat (n)
			send_pixel(PIX_W'($urandom_range(0, 24'hFFFFFF)));
		end_burst();
	endtask

	task automatic test_directed();
		logic [PIX_W-1:0] px[] = '{24'h000000, 24'hFFFFFF, 24'h808000, 24'h8080FF,
			24'h808064, 24'hFF80FF, 24'h00FF80, 24'hFF0000, 24'h0000FF, 24'h7F7F7F,
			24'h818180, 24'h55AA55, 24'hAA55AA};
		foreach (px[i])
			send_pixel(px[i]);
		end_burst();
	endtask

	task automatic test_light_extremes();
		logic [CFG_W-1:0] pos[] = '{9'd0, 9'd511, 9'd256, 9'd255, 9'd257, 9'd156};
		foreach (pos[i]) begin
			set_light(pos[i], pos[(i + 2) % pos.size()]);
			send_pixel(24'hFFFFFF);
			send_pixel(24'h000000);
			random_pixels(40);
		end
	endtask

	task automatic test_random_lights();
		repeat (16) begin
			set_light(CFG_W'($urandom_range(0, 511)), CFG_W'($urandom_range(0, 511)));
			random_pixels(60);
		end
	endtask

	task automatic test_backpressure();
		drain();
		hold_off = 1;
		random_pixels(120);
	endtask

	task automatic test_no_idle();
		drain();
		quiet = 1;
		set_light(CFG_W'($urandom_range(0, 511)), CFG_W'($urandom_range(0, 511)));
		random_pixels(200);
	endtask

	initial begin
		update_light();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_light_extremes();
		test_random_lights();
		test_backpressure();
		test_no_idle();
		drain();
		$display("Sent %0d pixels, checked %0d shades over 24 light positions,",
			pixels_sent, shades_seen);
		$display("including a long output hold-off and an idle-free stretch.");
		if (errors == 0)
			$display("** normal_map_diffuse_shader: PASSED **");
		else
			$display("** normal_map_diffuse_shader: FAILED **");
		$finish;
	end

endmodule
